FILE: rtl/bbit_pkg.sv
package bbit_pkg;

  localparam int TIME_BITS_DEFAULT = 32;
  localparam int ACC_BITS_DEFAULT  = 24;

  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [7:0]  PRESENCE_GAIN_RESET     = 8'd100;
  localparam logic [3:0]  FILTER_SHIFT_RESET      = 4'd10;
  localparam logic [7:0]  HIGH_THRESHOLD_RESET    = 8'd90;
  localparam logic [7:0]  LOW_THRESHOLD_RESET     = 8'd10;
  localparam logic [15:0] LOCKOUT_TICKS_RESET     = 16'd200;
  localparam logic [15:0] SESSION_GAP_TICKS_RESET = 16'd2000;

  localparam logic KIND_DEPART = 1'b0;
  localparam logic KIND_IMPACT = 1'b1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PRESENCE_GAIN     = 3'd0,
    REG_FILTER_SHIFT      = 3'd1,
    REG_HIGH_THRESHOLD    = 3'd2,
    REG_LOW_THRESHOLD     = 3'd3,
    REG_LOCKOUT_TICKS     = 3'd4,
    REG_SESSION_GAP_TICKS = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [7:0]  presence_gain;
    logic [3:0]  filter_shift;
    logic [7:0]  high_threshold;
    logic [7:0]  low_threshold;
    logic [15:0] lockout_ticks;
    logic [15:0] session_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic        clear;
    logic        has_event;
    logic        kind;
    logic        over_gap;
    logic [31:0] event_time;
    logic [31:0] interval;
  } entry_t;

endpackage

FILE: rtl/bbit_in_if.sv
interface bbit_in_if;
  logic valid;
  logic ready;
  logic tick;
  logic ir_edge;
  logic clear_session;

  modport source (output valid, output tick, output ir_edge, output clear_session,
                  input ready);
  modport sink (input valid, input tick, input ir_edge, input clear_session,
                output ready);
endinterface

FILE: rtl/bbit_out_if.sv
interface bbit_out_if;
  logic        valid;
  logic        ready;
  logic        event_kind;
  logic [31:0] event_time;
  logic [31:0] stay_time;
  logic [31:0] bounce_number;
  logic [31:0] air_time;
  logic [31:0] total_air_time;
  logic        new_session;

  modport source (output valid, output event_kind, output event_time, output stay_time,
                  output bounce_number, output air_time, output total_air_time,
                  output new_session, input ready);
  modport sink (input valid, input event_kind, input event_time, input stay_time,
                input bounce_number, input air_time, input total_air_time,
                input new_session, output ready);
endinterface

FILE: rtl/beam_break_interval_timer_unit.sv
// Beam-break interval timer. Each input beat is one sample holding a millisecond tick flag,
// an IR edge flag and a session clear flag; a sample yields at most one event beat,
// either a depart (state goes up, with the stay time) or an impact (state goes down,
// with bounce number, air time and running total). A new sample is taken every cycle
// while the queue is not full; the filter, threshold and lockout decision for one sample
// complete in the cycle it is accepted; its event then leaves through a four-entry queue
// and an output register, so input stops only once the output stalls and the queue fills.
// Configuration registers are written by index and should change only while no events
// are pending.
module beam_break_interval_timer_unit #(
  parameter int TIME_BITS = bbit_pkg::TIME_BITS_DEFAULT,
  parameter int ACC_BITS  = bbit_pkg::ACC_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [bbit_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bbit_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  bbit_in_if.sink                            in_ch,
  bbit_out_if.source                         out_ch
);

  bbit_pkg::cfg_t   cfg;
  logic             push;
  bbit_pkg::entry_t push_entry;
  logic             full;
  logic             pop;
  bbit_pkg::entry_t head;
  logic             head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.presence_gain     <= bbit_pkg::PRESENCE_GAIN_RESET;
      cfg.filter_shift      <= bbit_pkg::FILTER_SHIFT_RESET;
      cfg.high_threshold    <= bbit_pkg::HIGH_THRESHOLD_RESET;
      cfg.low_threshold     <= bbit_pkg::LOW_THRESHOLD_RESET;
      cfg.lockout_ticks     <= bbit_pkg::LOCKOUT_TICKS_RESET;
      cfg.session_gap_ticks <= bbit_pkg::SESSION_GAP_TICKS_RESET;
    end else if (cfg_write) begin
      case (bbit_pkg::reg_index_t'(cfg_index))
        bbit_pkg::REG_PRESENCE_GAIN:     cfg.presence_gain     <= cfg_data[7:0];
        bbit_pkg::REG_FILTER_SHIFT:      cfg.filter_shift      <= cfg_data[3:0];
        bbit_pkg::REG_HIGH_THRESHOLD:    cfg.high_threshold    <= cfg_data[7:0];
        bbit_pkg::REG_LOW_THRESHOLD:     cfg.low_threshold     <= cfg_data[7:0];
        bbit_pkg::REG_LOCKOUT_TICKS:     cfg.lockout_ticks     <= cfg_data[15:0];
        bbit_pkg::REG_SESSION_GAP_TICKS: cfg.session_gap_ticks <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  bbit_front #(
    .TIME_BITS(TIME_BITS),
    .ACC_BITS (ACC_BITS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .in_ch(in_ch),
    .push (push),
    .entry(push_entry),
    .full (full)
  );

  bbit_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid)
  );

  bbit_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

FILE: rtl/bbit_front.sv
module bbit_front #(
  parameter int TIME_BITS = bbit_pkg::TIME_BITS_DEFAULT,
  parameter int ACC_BITS  = bbit_pkg::ACC_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  bbit_pkg::cfg_t   cfg,
  bbit_in_if.sink          in_ch,
  output logic             push,
  output bbit_pkg::entry_t entry,
  input  logic             full
);

  logic [TIME_BITS-1:0] tick_count;
  logic [TIME_BITS-1:0] last_ir_tick;
  logic [ACC_BITS-1:0]  integrator;
  logic                 is_up;
  logic [TIME_BITS-1:0] depart_stamp;
  logic [TIME_BITS-1:0] impact_stamp;

  logic                 accept;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] last_ir_tick_next;
  logic [TIME_BITS-1:0] since_ir;
  logic                 present;
  logic [ACC_BITS-1:0]  level;
  logic [ACC_BITS:0]    acc_sum;
  logic [ACC_BITS-1:0]  integrator_next;
  logic [TIME_BITS-1:0] since_impact;
  logic [TIME_BITS-1:0] since_depart;
  logic [TIME_BITS-1:0] lockout;
  logic                 unlocked;
  logic                 above_high;
  logic                 below_low;
  logic                 go_up;
  logic                 go_down;
  logic [TIME_BITS-1:0] interval;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  always_comb begin
    now               = in_ch.tick ? tick_count + TIME_BITS'(1) : tick_count;
    last_ir_tick_next = in_ch.ir_edge ? now : last_ir_tick;
    since_ir          = now - last_ir_tick_next;
    present           = since_ir <= TIME_BITS'(1);
    level             = integrator >> cfg.filter_shift;
    acc_sum           = {1'b0, integrator}
                      + (present ? (ACC_BITS+1)'(cfg.presence_gain) : '0)
                      - {1'b0, level};
    integrator_next   = acc_sum[ACC_BITS] ? '1 : acc_sum[ACC_BITS-1:0];
    since_impact      = now - impact_stamp;
    since_depart      = now - depart_stamp;
    lockout           = TIME_BITS'(cfg.lockout_ticks);
    unlocked          = (since_impact > lockout) && (since_depart > lockout);
    above_high        = level > ACC_BITS'(cfg.high_threshold);
    below_low         = level < ACC_BITS'(cfg.low_threshold);
    go_up             = above_high && unlocked && !is_up;
    go_down           = !above_high && below_low && unlocked && is_up;
    interval          = go_up ? since_impact : since_depart;
  end

  always_comb begin
    entry.clear      = in_ch.clear_session;
    entry.has_event  = go_up || go_down;
    entry.kind       = go_down ? bbit_pkg::KIND_IMPACT : bbit_pkg::KIND_DEPART;
    entry.over_gap   = interval > TIME_BITS'(cfg.session_gap_ticks);
    entry.event_time = 32'(now);
    entry.interval   = 32'(interval);
    push             = accept && (in_ch.clear_session || go_up || go_down);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      last_ir_tick <= '0;
      integrator   <= '0;
      is_up        <= 1'b0;
      depart_stamp <= '0;
      impact_stamp <= '0;
    end else if (accept) begin
      tick_count   <= now;
      last_ir_tick <= last_ir_tick_next;
      integrator   <= integrator_next;
      if (go_up) begin
        is_up        <= 1'b1;
        depart_stamp <= now;
      end
      if (go_down) begin
        is_up        <= 1'b0;
        impact_stamp <= now;
      end
    end
  end

endmodule

FILE: rtl/bbit_queue.sv
module bbit_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bbit_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output bbit_pkg::entry_t head,
  output logic             head_valid
);

  localparam int DEPTH      = bbit_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  bbit_pkg::entry_t       slots [DEPTH];
  logic [PTR_BITS-1:0]    wr_ptr;
  logic [PTR_BITS-1:0]    rd_ptr;
  logic [COUNT_BITS-1:0]  count;

  assign full       = count == COUNT_BITS'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + COUNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_BITS'(1);
      end
    end
  end

endmodule

FILE: rtl/bbit_back.sv
module bbit_back (
  input  logic             clk,
  input  logic             rst,
  input  bbit_pkg::entry_t head,
  input  logic             head_valid,
  output logic             pop,
  bbit_out_if.source       out_ch
);

  logic [31:0] air_sum;
  logic [31:0] bounce_counter;

  logic        load_ok;
  logic [31:0] bounce_base;
  logic [31:0] sum_base;
  logic [31:0] bounce_report;
  logic [31:0] sum_report;
  logic [31:0] bounce_counter_next;
  logic [31:0] air_sum_next;

  logic        valid;
  logic        kind;
  logic [31:0] event_time;
  logic [31:0] stay_time;
  logic [31:0] bounce_number;
  logic [31:0] air_time;
  logic [31:0] total_air_time;
  logic        new_session;

  assign load_ok = !valid || out_ch.ready;
  assign pop     = head_valid && (!head.has_event || load_ok);

  always_comb begin
    bounce_base = head.clear ? 32'd1 : bounce_counter;
    sum_base    = head.clear ? 32'd0 : air_sum;
    if (!head.has_event) begin
      bounce_report = bounce_base;
      sum_report    = sum_base;
    end else if (head.kind == bbit_pkg::KIND_IMPACT) begin
      bounce_report = head.over_gap ? 32'd1 : bounce_base;
      sum_report    = head.over_gap ? 32'd0 : sum_base + head.interval;
    end else begin
      bounce_report = head.over_gap ? 32'd1 : bounce_base;
      sum_report    = head.over_gap ? 32'd0 : sum_base;
    end
    if (head.has_event && head.kind == bbit_pkg::KIND_IMPACT) begin
      bounce_counter_next = bounce_report + 32'd1;
    end else begin
      bounce_counter_next = bounce_report;
    end
    air_sum_next = sum_report;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      air_sum        <= '0;
      bounce_counter <= '0;
    end else if (pop) begin
      air_sum        <= air_sum_next;
      bounce_counter <= bounce_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_ok) begin
      valid <= pop && head.has_event;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && pop && head.has_event) begin
      kind           <= head.kind;
      event_time     <= head.event_time;
      stay_time      <= (head.kind == bbit_pkg::KIND_DEPART) ? head.interval : 32'd0;
      air_time       <= (head.kind == bbit_pkg::KIND_IMPACT) ? head.interval : 32'd0;
      bounce_number  <= bounce_report;
      total_air_time <= sum_report;
      new_session    <= head.over_gap;
    end
  end

  assign out_ch.valid          = valid;
  assign out_ch.event_kind     = kind;
  assign out_ch.event_time     = event_time;
  assign out_ch.stay_time      = stay_time;
  assign out_ch.bounce_number  = bounce_number;
  assign out_ch.air_time       = air_time;
  assign out_ch.total_air_time = total_air_time;
  assign out_ch.new_session    = new_session;

endmodule
